### hw/rtl/iqu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqu_pkg
// shared types, constants and the sine table generator for the iq upconverter
// ----------------------------------------------------------------------------
package iqu_pkg;

  // default parameter values
  localparam int SAMPLE_WIDTH_DEF    = 16;
  localparam int PHASE_WIDTH_DEF     = 32;
  localparam int SINE_TABLE_BITS_DEF = 10;

  // fixed widths
  localparam int CODE_W     = 16;  // dac code word
  localparam int CFG_DATA_W = 32;  // widest register
  localparam int CFG_IDX_W  = 3;
  localparam int FIFO_DEPTH = 4;   // power of two

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP = 3'd0,
    REG_AMP_RATIO  = 3'd1,
    REG_SKEW_SIN   = 3'd2,
    REG_SKEW_COS   = 3'd3,
    REG_DC_I       = 3'd4,
    REG_DC_Q       = 3'd5,
    REG_RESOLUTION = 3'd6
  } cfg_reg_e;

  // effective dac resolution
  typedef enum logic [1:0] {
    RES_14,
    RES_15,
    RES_16
  } res_t;

  typedef struct packed {
    logic        [31:0] phase_step;
    logic        [15:0] amp_ratio;
    logic signed [14:0] skew_sin;
    logic        [14:0] skew_cos;
    logic signed [14:0] dc_i;
    logic signed [14:0] dc_q;
    res_t               res;
  } cfg_t;

  // first quadrant sine in unsigned q0.15, m in 0 .. 2^(table_bits-2), q30 taylor series
  function automatic logic [14:0] quarter_sine(input longint unsigned m,
                                               input int unsigned table_bits);
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint          sum;
    a    = (m * HALF_PI_Q30) >> (table_bits - 2);
    a2   = (a * a) >> 30;
    term = a;
    sum  = longint'(a);
    term = ((term * a2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * a2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * a2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * a2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * a2) >> 30) / 110;
    sum  = sum - longint'(term);
    term = ((term * a2) >> 30) / 156;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 16384) >>> 15;
    if (sum > 32767) begin
      sum = 32767;
    end
    return 15'(sum);
  endfunction

endpackage

### hw/rtl/iqu_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqu_in_if
// envelope sample channel: valid, ready and one complex sample word
// ----------------------------------------------------------------------------
interface iqu_in_if #(
  parameter int SAMPLE_WIDTH = iqu_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] env_i;
  logic signed [SAMPLE_WIDTH-1:0] env_q;
  logic                           record_start;

  modport source (output valid, output env_i, output env_q, output record_start,
                  input ready);
  modport sink (input valid, input env_i, input env_q, input record_start,
                output ready);
endinterface

### hw/rtl/iqu_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqu_out_if
// dac code channel: valid, ready and one pair of codes with the clip flag
// ----------------------------------------------------------------------------
interface iqu_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [iqu_pkg::CODE_W-1:0] code_i;
  logic signed [iqu_pkg::CODE_W-1:0] code_q;
  logic                             clipped;

  modport source (output valid, output code_i, output code_q, output clipped,
                  input ready);
  modport sink (input valid, input code_i, input code_q, input clipped,
                output ready);
endinterface

### hw/rtl/iqu_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqu_fifo
// short show-ahead queue between the phase front end and the datapath
// ----------------------------------------------------------------------------
module iqu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = iqu_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);
  import iqu_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (PTR_W + 1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

### hw/rtl/iqu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqu_front
// accepts samples, picks the phase of each one and steps the accumulator
// ----------------------------------------------------------------------------
module iqu_front #(
  parameter int SAMPLE_WIDTH    = iqu_pkg::SAMPLE_WIDTH_DEF,
  parameter int PHASE_WIDTH     = iqu_pkg::PHASE_WIDTH_DEF,
  parameter int SINE_TABLE_BITS = iqu_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  iqu_pkg::cfg_t                             cfg,
  iqu_in_if.sink                                    samples,
  input  logic                                      q_full,
  output logic                                      q_push,
  output logic [2*SAMPLE_WIDTH+SINE_TABLE_BITS-1:0] q_word
);
  import iqu_pkg::*;

  logic [PHASE_WIDTH-1:0]     phase_acc;
  logic [PHASE_WIDTH-1:0]     phase;
  logic [PHASE_WIDTH-1:0]     step_aligned;
  logic [SINE_TABLE_BITS-1:0] idx;

  // step aligned to the top of the accumulator
  if (PHASE_WIDTH >= 32) begin : g_step_up
    assign step_aligned = PHASE_WIDTH'(cfg.phase_step) << (PHASE_WIDTH - 32);
  end else begin : g_step_down
    assign step_aligned = PHASE_WIDTH'(cfg.phase_step >> (32 - PHASE_WIDTH));
  end

  assign phase         = samples.record_start ? '0 : phase_acc;
  assign idx           = phase[PHASE_WIDTH-1 -: SINE_TABLE_BITS];
  assign samples.ready = !q_full;
  assign q_push        = samples.valid && !q_full;
  assign q_word        = {samples.env_i, samples.env_q, idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (q_push) begin
      phase_acc <= phase + step_aligned;
    end
  end
endmodule

### hw/rtl/iqu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqu_back
// rotation, mixer predistortion and dac quantisation pipeline
// ----------------------------------------------------------------------------
module iqu_back #(
  parameter int SAMPLE_WIDTH    = iqu_pkg::SAMPLE_WIDTH_DEF,
  parameter int SINE_TABLE_BITS = iqu_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  iqu_pkg::cfg_t                             cfg,
  input  logic                                      q_empty,
  input  logic [2*SAMPLE_WIDTH+SINE_TABLE_BITS-1:0] q_word,
  output logic                                      q_pop,
  iqu_out_if.source                                 codes
);
  import iqu_pkg::*;

  localparam int B       = SINE_TABLE_BITS;
  localparam int MW      = B - 1;          // quarter table address
  localparam int QUARTER = 1 << (B - 2);
  localparam int SW      = 24;             // q1.23 working sample
  localparam int UP      = SW - SAMPLE_WIDTH;
  localparam int PRW     = 40;             // rotation products
  localparam int RW      = 41;             // rotated value
  localparam int GPW     = RW + 17;        // gain product
  localparam int GW      = 42;             // gain scaled q
  localparam int TPW     = GW + 16;        // skew products
  localparam int VW      = 44;             // predistorted value
  localparam int CW      = 22;             // rounded code before clamp
  localparam int XW      = 60;             // rounding helper width
  localparam int STAGES  = 8;

  function automatic logic signed [XW-1:0] round_shift(input logic signed [XW-1:0] x,
                                                       input logic [5:0] s);
    logic [XW-1:0] mag;
    mag = x[XW-1] ? XW'(-x) : XW'(x);
    mag = (mag + (XW'(1) << (s - 6'd1))) >> s;
    return x[XW-1] ? -signed'(mag) : signed'(mag);
  endfunction

  // fold a full-turn index onto the first quadrant
  function automatic logic [MW-1:0] fold(input logic [B-1:0] k);
    return k[B-2] ? (MW'(QUARTER) - MW'(k[B-3:0])) : MW'(k[B-3:0]);
  endfunction

  // quarter wave rom, two registered read ports
  logic [14:0] rom [QUARTER+1];
  for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
    assign rom[k] = quarter_sine(longint'(k), B);
  end

  logic                   adv;
  logic [STAGES-1:0]      vpipe;
  logic signed [SAMPLE_WIDTH-1:0] head_i;
  logic signed [SAMPLE_WIDTH-1:0] head_q;
  logic [B-1:0]           k_sin;
  logic [B-1:0]           k_cos;
  logic [MW-1:0]          m_sin;
  logic [MW-1:0]          m_cos;

  // stage registers
  logic signed [SW-1:0]   si1, sq1;
  logic [14:0]            sin_mag, cos_mag;
  logic                   sin_neg, cos_neg;
  logic signed [15:0]     sn, cs;
  logic signed [PRW-1:0]  p_ic, p_qs, p_is, p_qc;
  logic signed [RW-1:0]   ri3, rq3, ri4, ri5, ri6;
  logic signed [GPW-1:0]  gprod;
  logic signed [GW-1:0]   gq;
  logic signed [TPW-1:0]  tprod_i, tprod_q;
  logic signed [VW-1:0]   vi, vq;
  logic signed [CW-1:0]   ci, cq;
  logic [5:0]             code_shift;
  logic signed [CW-1:0]   code_hi, code_lo;
  res_t                   res8;

  assign adv   = !codes.valid || codes.ready;
  assign q_pop = adv && !q_empty;

  assign {head_i, head_q} = q_word[2*SAMPLE_WIDTH+B-1:B];
  assign k_sin = q_word[B-1:0];
  assign k_cos = k_sin + B'(QUARTER);
  assign m_sin = fold(k_sin);
  assign m_cos = fold(k_cos);

  always_comb begin
    sn = sin_neg ? -signed'({1'b0, sin_mag}) : signed'({1'b0, sin_mag});
    cs = cos_neg ? -signed'({1'b0, cos_mag}) : signed'({1'b0, cos_mag});
  end

  always_comb begin
    unique case (res8)
      RES_14: begin
        code_shift = 6'd25;
        code_hi    = CW'(8191);
        code_lo    = -CW'(8192);
      end
      RES_15: begin
        code_shift = 6'd24;
        code_hi    = CW'(16383);
        code_lo    = -CW'(16384);
      end
      default: begin
        code_shift = 6'd23;
        code_hi    = CW'(32767);
        code_lo    = -CW'(32768);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe       <= '0;
      codes.valid <= 1'b0;
    end else if (adv) begin
      vpipe       <= {vpipe[STAGES-2:0], !q_empty};
      codes.valid <= vpipe[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // table lookup
      si1     <= SW'(head_i) <<< UP;
      sq1     <= SW'(head_q) <<< UP;
      sin_mag <= rom[m_sin];
      cos_mag <= rom[m_cos];
      sin_neg <= k_sin[B-1];
      cos_neg <= k_cos[B-1];
      // rotation products
      p_ic <= PRW'(si1) * PRW'(cs);
      p_qs <= PRW'(sq1) * PRW'(sn);
      p_is <= PRW'(si1) * PRW'(sn);
      p_qc <= PRW'(sq1) * PRW'(cs);
      // conjugate rotation sums
      ri3 <= RW'(p_ic) + RW'(p_qs);
      rq3 <= RW'(p_is) - RW'(p_qc);
      // gain
      gprod <= GPW'(rq3) * signed'(GPW'({1'b0, cfg.amp_ratio}));
      ri4   <= ri3;
      gq    <= GW'(round_shift(XW'(gprod), 6'd14));
      ri5   <= ri4;
      // skew
      tprod_i <= TPW'(gq) * TPW'(cfg.skew_sin);
      tprod_q <= TPW'(gq) * signed'(TPW'({1'b0, cfg.skew_cos}));
      ri6     <= ri5;
      // predistortion sums
      vi <= VW'(ri6) - VW'(round_shift(XW'(tprod_i), 6'd15))
            + (VW'(cfg.dc_i) <<< 23);
      vq <= VW'(round_shift(XW'(tprod_q), 6'd15)) + (VW'(cfg.dc_q) <<< 23);
      res8 <= cfg.res;
      // code rounding
      ci <= CW'(round_shift(XW'(vi), code_shift));
      cq <= CW'(round_shift(XW'(vq), code_shift));
      // clamp into the output register
      codes.code_i  <= (ci > code_hi) ? CODE_W'(code_hi) :
                       (ci < code_lo) ? CODE_W'(code_lo) : CODE_W'(ci);
      codes.code_q  <= (cq > code_hi) ? CODE_W'(code_hi) :
                       (cq < code_lo) ? CODE_W'(code_lo) : CODE_W'(cq);
      codes.clipped <= (ci > code_hi) || (ci < code_lo) ||
                       (cq > code_hi) || (cq < code_lo);
    end
  end
endmodule

### hw/rtl/iq_upconvert_predistort_quantise_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iq_upconvert_predistort_quantise_top
// iq upconverter with mixer predistortion and dac quantisation
// ----------------------------------------------------------------------------
// usage
//   samples : one complex envelope word per handshake (env_i, env_q in q1.x,
//             record_start restarts the carrier phase at zero for that word)
//   codes   : one word per sample with the two signed dac codes and a clip flag
//   cfg     : plain write port, cfg_write with cfg_index and cfg_data; write
//             only while the block is idle, unused indexes are ignored
// timing
//   a sample accepted on samples passes through the queue and the nine-deep
//   multiply pipeline to codes; one sample per cycle is sustained while the
//   sink keeps ready high, set by the pipeline and its two-port quarter-wave sine rom
// flow
//   the front end stamps each sample with its phase and drops it in a four
//   word queue; the datapath drains the queue and stalls as a whole when the
//   output register holds a word the sink has not taken, the queue then fills
//   and samples.ready falls
// reset
//   rst clears the phase accumulator, the queue and all valid flags and loads
//   the register defaults (unity gain ratio, no skew, no offset, 14 bit dac)
// ----------------------------------------------------------------------------
module iq_upconvert_predistort_quantise_top #(
  parameter int SAMPLE_WIDTH    = iqu_pkg::SAMPLE_WIDTH_DEF,
  parameter int PHASE_WIDTH     = iqu_pkg::PHASE_WIDTH_DEF,
  parameter int SINE_TABLE_BITS = iqu_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  iqu_in_if.sink                           samples,
  iqu_out_if.source                        codes,
  input  logic                             cfg_write,
  input  logic [iqu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [iqu_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import iqu_pkg::*;

  localparam int QW = 2 * SAMPLE_WIDTH + SINE_TABLE_BITS;  // queue word

  // configuration registers
  logic [31:0]        phase_step;
  logic [15:0]        amp_ratio;
  logic signed [14:0] skew_sin;
  logic [14:0]        skew_cos;
  logic signed [14:0] dc_i;
  logic signed [14:0] dc_q;
  logic [4:0]         dac_bits;
  cfg_t               cfg;

  // queue between front end and datapath
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic [QW-1:0] q_in;
  logic [QW-1:0] q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      amp_ratio  <= 16'd16384;
      skew_sin   <= '0;
      skew_cos   <= 15'd32767;
      dc_i       <= '0;
      dc_q       <= '0;
      dac_bits   <= 5'd14;
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_PHASE_STEP: phase_step <= cfg_data;
        REG_AMP_RATIO:  amp_ratio  <= cfg_data[15:0];
        REG_SKEW_SIN:   skew_sin   <= signed'(cfg_data[14:0]);
        REG_SKEW_COS:   skew_cos   <= cfg_data[14:0];
        REG_DC_I:       dc_i       <= signed'(cfg_data[14:0]);
        REG_DC_Q:       dc_q       <= signed'(cfg_data[14:0]);
        REG_RESOLUTION: dac_bits   <= cfg_data[4:0];
        default:        ;  // index past the register map
      endcase
    end
  end

  // resolution below 14 acts as 14, above 16 as 16
  always_comb begin
    cfg.phase_step = phase_step;
    cfg.amp_ratio  = amp_ratio;
    cfg.skew_sin   = skew_sin;
    cfg.skew_cos   = skew_cos;
    cfg.dc_i       = dc_i;
    cfg.dc_q       = dc_q;
    priority if (dac_bits <= 5'd14) begin
      cfg.res = RES_14;
    end else if (dac_bits == 5'd15) begin
      cfg.res = RES_15;
    end else begin
      cfg.res = RES_16;
    end
  end

  iqu_front #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .PHASE_WIDTH     (PHASE_WIDTH),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .samples (samples),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_word  (q_in)
  );

  iqu_fifo #(
    .WIDTH (QW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .pop   (q_pop),
    .dout  (q_out),
    .full  (q_full),
    .empty (q_empty)
  );

  iqu_back #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_word  (q_out),
    .q_pop   (q_pop),
    .codes   (codes)
  );
endmodule
